[rtl/assert_macros.svh]
// Assertion macros shared by the character cell pixel generator RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// A condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/cclpg_pkg.sv]
// Package of the character cell pixel generator: types, constants and helpers.
// Depends on nothing; used by every module of the block but cclpg_fifo.
`timescale 1ns / 1ps
`default_nettype none

package cclpg_pkg;

	// Register map of the configuration port.
	typedef enum logic [2:0] {
		REG_SCREEN_BANK  = 3'd0,
		REG_CHARSET_BANK = 3'd1,
		REG_ADDR_BIT9    = 3'd2,
		REG_COLUMNS      = 3'd3,
		REG_BACKGROUND   = 3'd4,
		REG_BORDER       = 3'd5,
		REG_AUXILIARY    = 3'd6,
		REG_REVERSE      = 3'd7
	} reg_index_t;

	localparam int unsigned CFG_DATA_W    = 7;
	localparam logic [6:0]  DEFAULT_COLUMNS = 7'd22;
	localparam logic [15:0] COLOR_BASE      = 16'h9400;
	localparam logic [2:0]  PIXEL_LAST      = 3'd7;
	localparam int unsigned QUEUE_DEPTH     = 2;

	// Configuration register set.
	typedef struct packed {
		logic [3:0] screen_bank;
		logic [3:0] charset_bank;
		logic       address_bit_nine;
		logic [6:0] columns_in_use;
		logic [3:0] background_index;
		logic [2:0] border_index;
		logic [3:0] auxiliary_index;
		logic       reverse_mode;
	} cfg_t;

	// One classified cell line as it waits in the queue.
	typedef struct packed {
		logic [6:0]  column;
		logic [8:0]  pixel_y;
		logic [15:0] screen_address;
		logic [15:0] color_address;
		logic [15:0] pattern_address;
		logic [2:0]  fg;
		logic        multi;
		logic [7:0]  pattern;
	} item_t;

	// One pixel result.
	typedef struct packed {
		logic [9:0]  pixel_x;
		logic [8:0]  pixel_y;
		logic [3:0]  color_index;
		logic [15:0] screen_address;
		logic [15:0] color_address;
		logic [15:0] pattern_address;
		logic        last;
	} result_t;

	// Bank selector to base address: bits 2..0 land at bit 10, and a clear
	// bit 3 adds the 32 KiB offset.
	function automatic logic [15:0] bank_base(input logic [3:0] sel);
		bank_base = {~sel[3], 2'b00, sel[2:0], 10'b0};
	endfunction

endpackage

`default_nettype wire

[rtl/cclpg_fifo.sv]
// Short register queue between the front and back parts of the pixel generator.
// Depends on assert_macros.svh only.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cclpg_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_NEVER(a_no_push_when_full, clk, arst_n, push && full, "queue pushed while full")
	`ASSERT_NEVER(a_count_in_range, clk, arst_n, count_q > CNT_W'(DEPTH), "queue count overflow")

endmodule

`default_nettype wire

[rtl/cclpg_front.sv]
// Front part: accepts cell line requests, forms the three addresses and pushes
// the classified item into the queue. Depends on cclpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cclpg_front
	import cclpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [6:0] column,
	input  logic [5:0] row,
	input  logic [2:0] char_line,
	input  logic [7:0] screen_code,
	input  logic [3:0] color_code,
	input  logic [7:0] pattern,
	input  cfg_t       cfg,
	input  logic       queue_full,
	output logic       busy,
	output logic       push,
	output item_t      item
);

	logic        valid_s1;
	item_t       item_s1;
	item_t       item_d;
	logic        accept;
	logic [6:0]  stride;
	logic [12:0] offset;
	logic [15:0] bit9;

	assign push   = valid_s1 && !queue_full;
	assign busy   = valid_s1 && queue_full;
	assign accept = start && !busy;
	assign item   = item_s1;

	// Address formation: row stride product plus column, then base offsets.
	always_comb begin
		stride = (cfg.columns_in_use == '0) ? DEFAULT_COLUMNS : cfg.columns_in_use;
		offset = 13'(row) * 13'(stride) + {6'b0, column};
		bit9   = {6'b0, cfg.address_bit_nine, 9'b0};
		item_d.column          = column;
		item_d.pixel_y         = {row, char_line};
		item_d.screen_address  = (bank_base(cfg.screen_bank) | bit9) + {3'b0, offset};
		item_d.color_address   = (COLOR_BASE | bit9) + {3'b0, offset};
		item_d.pattern_address = bank_base(cfg.charset_bank) + {5'b0, screen_code, char_line};
		item_d.fg              = color_code[2:0];
		item_d.multi           = color_code[3];
		item_d.pattern         = pattern;
	end

	// Request stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Request stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

[rtl/cclpg_back.sv]
// Back part: takes items from the queue and emits eight pixels per item, one a
// cycle, with the color choice. Depends on cclpg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cclpg_back
	import cclpg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    queue_empty,
	input  item_t   head,
	output logic    pop,
	output logic    strobe,
	output result_t result
);

	item_t      cur_q;
	logic [2:0] cnt_q;
	logic       active_q;
	logic       strobe_q;
	result_t    result_q;
	result_t    result_d;
	logic [1:0] v;
	logic [3:0] fg4;

	assign pop    = !queue_empty && (!active_q || cnt_q == PIXEL_LAST);
	assign strobe = strobe_q;
	assign result = result_q;

	// Pixel value: a 2-bit pair in multicolor, the pattern bit doubled in hires.
	always_comb begin
		if (cur_q.multi) begin
			case (cnt_q[2:1])
				2'd0:    v = cur_q.pattern[7:6];
				2'd1:    v = cur_q.pattern[5:4];
				2'd2:    v = cur_q.pattern[3:2];
				default: v = cur_q.pattern[1:0];
			endcase
		end else begin
			v = {cur_q.pattern[3'd7 - cnt_q], 1'b0};
		end
	end

	// Color choice and the rest of the result.
	always_comb begin
		fg4 = {1'b0, cur_q.fg};
		case (v)
			2'd0:    result_d.color_index = cfg.reverse_mode ? fg4 : cfg.background_index;
			2'd1:    result_d.color_index = {1'b0, cfg.border_index};
			2'd2:    result_d.color_index = cfg.reverse_mode ? cfg.background_index : fg4;
			default: result_d.color_index = cfg.auxiliary_index;
		endcase
		result_d.pixel_x         = {cur_q.column, cnt_q};
		result_d.pixel_y         = cur_q.pixel_y;
		result_d.screen_address  = cur_q.screen_address;
		result_d.color_address   = cur_q.color_address;
		result_d.pattern_address = cur_q.pattern_address;
		result_d.last            = (cnt_q == PIXEL_LAST);
	end

	// Pixel sequencer and output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q && cnt_q == PIXEL_LAST) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// Current item and output payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		result_q <= result_d;
	end

	`ASSERT_PROP(a_pixels_contiguous, clk, arst_n, strobe_q && !result_q.last |=> strobe_q, "pixel run broken before last")
	`ASSERT_PROP(a_count_steps, clk, arst_n, active_q && cnt_q != PIXEL_LAST |=> active_q && cnt_q == $past(cnt_q) + 3'd1, "pixel count skipped")

endmodule

`default_nettype wire

[rtl/char_cell_line_pixel_generator_core.sv]
// Character cell line pixel generator: config registers, front, queue and back.
// Depends on cclpg_pkg, cclpg_front, cclpg_fifo and cclpg_back.
`timescale 1ns / 1ps
`default_nettype none

// Each request (start high while busy is low) is one line of one character
// cell; it yields eight pixel results, left to right, each shown for exactly
// one cycle with strobe high and last set on the eighth. The receiver cannot
// hold results off. The back part emits one pixel per cycle, so a steady
// stream of requests yields pixels with no gaps; the first pixel of a
// request goes through the request stage, queue, item and output registers.
// A short queue lets requests be taken while a line is still being emitted;
// busy rises only when the request stage is occupied and the queue is full.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data and should change only while no pixels are pending.
module char_cell_line_pixel_generator_core
	import cclpg_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [6:0]            column,
	input  logic [5:0]            row,
	input  logic [2:0]            char_line,
	input  logic [7:0]            screen_code,
	input  logic [3:0]            color_code,
	input  logic [7:0]            pattern,
	input  logic                  cfg_write,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  strobe,
	output logic [9:0]            pixel_x,
	output logic [8:0]            pixel_y,
	output logic [3:0]            color_index,
	output logic [15:0]           screen_address,
	output logic [15:0]           color_address,
	output logic [15:0]           pattern_address,
	output logic                  last
);

	cfg_t    cfg_q;
	logic    push;
	logic    pop;
	logic    queue_full;
	logic    queue_empty;
	item_t   front_item;
	item_t   head_item;
	result_t result;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_bank      <= '0;
			cfg_q.charset_bank     <= '0;
			cfg_q.address_bit_nine <= 1'b0;
			cfg_q.columns_in_use   <= DEFAULT_COLUMNS;
			cfg_q.background_index <= '0;
			cfg_q.border_index     <= '0;
			cfg_q.auxiliary_index  <= '0;
			cfg_q.reverse_mode     <= 1'b0;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_SCREEN_BANK:  cfg_q.screen_bank      <= cfg_data[3:0];
				REG_CHARSET_BANK: cfg_q.charset_bank     <= cfg_data[3:0];
				REG_ADDR_BIT9:    cfg_q.address_bit_nine <= cfg_data[0];
				REG_COLUMNS:      cfg_q.columns_in_use   <= cfg_data[6:0];
				REG_BACKGROUND:   cfg_q.background_index <= cfg_data[3:0];
				REG_BORDER:       cfg_q.border_index     <= cfg_data[2:0];
				REG_AUXILIARY:    cfg_q.auxiliary_index  <= cfg_data[3:0];
				REG_REVERSE:      cfg_q.reverse_mode     <= cfg_data[0];
				default:          cfg_q                  <= cfg_q;
			endcase
		end
	end

	// Front part: request stage and address formation.
	cclpg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.column      (column),
		.row         (row),
		.char_line   (char_line),
		.screen_code (screen_code),
		.color_code  (color_code),
		.pattern     (pattern),
		.cfg         (cfg_q),
		.queue_full  (queue_full),
		.busy        (busy),
		.push        (push),
		.item        (front_item)
	);

	// Queue between front and back.
	cclpg_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_item),
		.pop     (pop),
		.rd_data (head_item),
		.full    (queue_full),
		.empty   (queue_empty)
	);

	// Back part: pixel sequencer.
	cclpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.queue_empty (queue_empty),
		.head        (head_item),
		.pop         (pop),
		.strobe      (strobe),
		.result      (result)
	);

	assign pixel_x         = result.pixel_x;
	assign pixel_y         = result.pixel_y;
	assign color_index     = result.color_index;
	assign screen_address  = result.screen_address;
	assign color_address   = result.color_address;
	assign pattern_address = result.pattern_address;
	assign last            = result.last;

endmodule

`default_nettype wire

[tb/sv/char_cell_line_pixel_generator_core_tb.sv]
// Self-checking testbench for char_cell_line_pixel_generator_core: directed lines, then random.
// Depends on cclpg_pkg and the core RTL; checks every pixel of every accepted request.
`timescale 1ns / 1ps

module char_cell_line_pixel_generator_core_tb;
	import cclpg_pkg::*;

	// Two-bit pattern pairs and the color each one selects.
	localparam logic [1:0] PAIR_BACK   = 2'd0;
	localparam logic [1:0] PAIR_BORDER = 2'd1;
	localparam logic [1:0] PAIR_FORE   = 2'd2;
	localparam logic [1:0] PAIR_AUX    = 2'd3;

	localparam int NUM_REGS       = 8;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 16;
	localparam int QUIET_LIMIT    = 2000;
	localparam int RANDOM_PHASES  = 7;
	localparam int LINES_PER_PHASE = 50;
	localparam int NUM_DIRECTED   = 18;
	localparam int NUM_PRESETS    = 5;

	// One request as the sender sees it.
	typedef struct packed {
		logic [6:0] column;
		logic [5:0] row;
		logic [2:0] char_line;
		logic [7:0] code;
		logic [3:0] color;
		logic [7:0] pattern;
	} cell_t;

	// One row of the directed table; typed rows carry their own expected values.
	typedef struct {
		int          preset;
		cell_t       stim;
		bit          typed;
		logic [15:0] scr;
		logic [15:0] clr;
		logic [15:0] pat;
		logic [3:0]  color;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [6:0]            column;
	logic [5:0]            row;
	logic [2:0]            char_line;
	logic [7:0]            screen_code;
	logic [3:0]            color_code;
	logic [7:0]            pattern;
	logic                  cfg_write;
	logic [2:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  strobe;
	logic [9:0]            pixel_x;
	logic [8:0]            pixel_y;
	logic [3:0]            color_index;
	logic [15:0]           screen_address;
	logic [15:0]           color_address;
	logic [15:0]           pattern_address;
	logic                  last;

	cfg_t    shadow_regs;
	result_t expected_pixels[$];
	int      mismatch_count = 0;
	int      pixels_checked = 0;
	int      lines_sent = 0;
	int      settings_used = 0;
	int      quiet_cycles = 0;

	logic [6:0]    preset_regs[NUM_PRESETS][NUM_REGS];
	directed_row_t directed_rows[NUM_DIRECTED];

	char_cell_line_pixel_generator_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.column          (column),
		.row             (row),
		.char_line       (char_line),
		.screen_code     (screen_code),
		.color_code      (color_code),
		.pattern         (pattern),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.strobe          (strobe),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.color_index     (color_index),
		.screen_address  (screen_address),
		.color_address   (color_address),
		.pattern_address (pattern_address),
		.last            (last)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Memory bank selector to base address: a clear top bit adds the upper 32 KiB.
	function automatic logic [15:0] bank_origin(input logic [3:0] sel);
		int unsigned slot;
		slot = sel[2:0] + (sel[3] ? 0 : 32);
		return 16'(slot * 1024);
	endfunction

	// Palette index for one pattern pair; reverse mode swaps back and fore.
	function automatic logic [3:0] pair_color(input logic [1:0] pair, input logic [2:0] fg);
		case (pair)
			PAIR_BACK:   return shadow_regs.reverse_mode ? {1'b0, fg} : shadow_regs.background_index;
			PAIR_BORDER: return {1'b0, shadow_regs.border_index};
			PAIR_FORE:   return shadow_regs.reverse_mode ? shadow_regs.background_index : {1'b0, fg};
			default:     return shadow_regs.auxiliary_index;
		endcase
	endfunction

	// Queue the eight pixels of one line with the given addresses and colors.
	task automatic queue_line(input cell_t c, input logic [15:0] scr, input logic [15:0] clr,
			input logic [15:0] pat, input logic [3:0] colors[8]);
		result_t r;
		for (int k = 0; k < 8; k++) begin
			r.pixel_x         = {c.column, 3'(k)};
			r.pixel_y         = {c.row, c.char_line};
			r.color_index     = colors[k];
			r.screen_address  = scr;
			r.color_address   = clr;
			r.pattern_address = pat;
			r.last            = (k == 7);
			expected_pixels.push_back(r);
		end
	endtask

	// Work out the pixels of one cell line from the current register copy.
	task automatic predict_line(input cell_t c);
		logic [15:0] stride;
		logic [15:0] offset;
		logic [15:0] bit9;
		logic [1:0]  pair;
		logic [3:0]  colors[8];
		stride = (shadow_regs.columns_in_use == 0) ? 16'(DEFAULT_COLUMNS)
			: 16'(shadow_regs.columns_in_use);
		offset = 16'(c.row) * stride + 16'(c.column);
		bit9 = shadow_regs.address_bit_nine ? 16'h0200 : 16'h0000;
		for (int k = 0; k < 8; k++) begin
			if (c.color[3])
				pair = c.pattern[7 - 2 * (k / 2) -: 2];
			else
				pair = {c.pattern[7 - k], 1'b0};
			colors[k] = pair_color(pair, c.color[2:0]);
		end
		queue_line(c, (bank_origin(shadow_regs.screen_bank) | bit9) + offset,
			(COLOR_BASE | bit9) + offset,
			bank_origin(shadow_regs.charset_bank) + {5'd0, c.code, 3'd0} + 16'(c.char_line),
			colors);
	endtask

	// Mirror one register write into the local copy.
	task automatic shadow_write(input logic [2:0] idx, input logic [6:0] data);
		case (reg_index_t'(idx))
			REG_SCREEN_BANK:  shadow_regs.screen_bank      = data[3:0];
			REG_CHARSET_BANK: shadow_regs.charset_bank     = data[3:0];
			REG_ADDR_BIT9:    shadow_regs.address_bit_nine = data[0];
			REG_COLUMNS:      shadow_regs.columns_in_use   = data[6:0];
			REG_BACKGROUND:   shadow_regs.background_index = data[3:0];
			REG_BORDER:       shadow_regs.border_index     = data[2:0];
			REG_AUXILIARY:    shadow_regs.auxiliary_index  = data[3:0];
			REG_REVERSE:      shadow_regs.reverse_mode     = data[0];
			default: ;
		endcase
	endtask

	// Write all registers back to back; the block must be idle.
	task automatic program_regs(input logic [6:0] vals[NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			shadow_write(3'(i), vals[i]);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// Hold off requests until every pending pixel has come out, then let the pipe settle.
	task automatic drain_pixels();
		start <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Present one request and return at the edge that takes it; start stays high.
	task automatic send_cell(input cell_t c);
		start       <= 1'b1;
		column      <= c.column;
		row         <= c.row;
		char_line   <= c.char_line;
		screen_code <= c.code;
		color_code  <= c.color;
		pattern     <= c.pattern;
		do
			@(posedge clk);
		while (busy);
		lines_sent++;
	endtask

	// When allowed, sometimes drop start for a random gap between requests.
	task automatic maybe_pause(input bit allowed);
		if (allowed && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
		end
	endtask

	// Compare every pixel on the result ports with the oldest expectation.
	always @(posedge clk) begin : check_pixels
		result_t want;
		if (arst_n && strobe) begin
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: pixel at x %0d y %0d with nothing expected",
						$realtime, pixel_x, pixel_y);
			end else begin
				want = expected_pixels.pop_front();
				pixels_checked++;
				check_field("pixel_x", 16'(want.pixel_x), 16'(pixel_x));
				check_field("pixel_y", 16'(want.pixel_y), 16'(pixel_y));
				check_field("color_index", 16'(want.color_index), 16'(color_index));
				check_field("screen_address", want.screen_address, screen_address);
				check_field("color_address", want.color_address, color_address);
				check_field("pattern_address", want.pattern_address, pattern_address);
				check_field("last", 16'(want.last), 16'(last));
			end
		end
	end

	// Watchdog: too long without a request, a pixel or a register write ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || cfg_write)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout after %0d quiet cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		cell_t      c;
		int         cur_preset;
		logic [6:0] regs[NUM_REGS];
		logic [3:0] colors[8];

		arst_n      <= 1'b0;
		start       <= 1'b0;
		column      <= '0;
		row         <= '0;
		char_line   <= '0;
		screen_code <= '0;
		color_code  <= '0;
		pattern     <= '0;
		cfg_write   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;

		// Register copy starts from the reset values.
		shadow_regs = '0;
		shadow_regs.columns_in_use = DEFAULT_COLUMNS;

		// Register presets, in register index order: reset values, all zero
		// (zero column count), all ones, high banks with address bit nine set, and
		// data with upper bits set beyond each narrower register's width.
		preset_regs[0] = '{7'd0, 7'd0, 7'd0, 7'd22, 7'd0, 7'd0, 7'd0, 7'd0};
		preset_regs[1] = '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
		preset_regs[2] = '{7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f};
		preset_regs[3] = '{7'd7, 7'd7, 7'd1, 7'd40, 7'd5, 7'd2, 7'd9, 7'd1};
		preset_regs[4] = '{7'h17, 7'h3b, 7'h02, 7'h01, 7'h1a, 7'h6d, 7'h25, 7'h40};

		// Directed lines: field extremes, hires and multicolor, every pair value,
		// reverse mode in both modes, zero column count and high banks.
		directed_rows = '{
			'{0, '{7'd0, 6'd0, 3'd0, 8'h00, 4'h0, 8'h00}, 1'b1, 16'h8000, 16'h9400, 16'h8000, 4'd0},
			'{0, '{7'd127, 6'd63, 3'd7, 8'hff, 4'h7, 8'hff}, 1'b1, 16'h85e9, 16'h99e9, 16'h87ff, 4'd7},
			'{0, '{7'd5, 6'd2, 3'd3, 8'h41, 4'hf, 8'hff}, 1'b1, 16'h8031, 16'h9431, 16'h820b, 4'd0},
			'{0, '{7'd10, 6'd4, 3'd1, 8'h20, 4'h3, 8'ha5}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{0, '{7'd21, 6'd7, 3'd6, 8'h80, 4'ha, 8'h1b}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{0, '{7'd64, 6'd32, 3'd4, 8'h7f, 4'h8, 8'he4}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{1, '{7'd1, 6'd1, 3'd0, 8'h00, 4'h0, 8'hff}, 1'b1, 16'h8017, 16'h9417, 16'h8000, 4'd0},
			'{1, '{7'd127, 6'd63, 3'd7, 8'hff, 4'hd, 8'h39}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{1, '{7'd0, 6'd63, 3'd2, 8'h55, 4'h6, 8'h5a}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{2, '{7'd0, 6'd0, 3'd0, 8'h00, 4'h0, 8'h00}, 1'b1, 16'h1e00, 16'h9600, 16'h1c00, 4'd0},
			'{2, '{7'd127, 6'd63, 3'd7, 8'hff, 4'hc, 8'h1b}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{2, '{7'd3, 6'd9, 3'd5, 8'haa, 4'h5, 8'hf0}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{3, '{7'd127, 6'd63, 3'd7, 8'hff, 4'hf, 8'h6c}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{3, '{7'd100, 6'd50, 3'd3, 8'hc3, 4'h9, 8'h1b}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{3, '{7'd0, 6'd0, 3'd0, 8'h00, 4'h2, 8'h0f}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{4, '{7'd127, 6'd63, 3'd7, 8'hff, 4'hb, 8'h1b}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{4, '{7'd0, 6'd0, 3'd0, 8'h00, 4'h7, 8'h81}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0},
			'{4, '{7'd55, 6'd31, 3'd4, 8'h3c, 4'he, 8'hc6}, 1'b0, 16'h0, 16'h0, 16'h0, 4'd0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: change the register preset only between drained groups.
		cur_preset = 0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].preset != cur_preset) begin
				drain_pixels();
				cur_preset = directed_rows[i].preset;
				regs = preset_regs[cur_preset];
				program_regs(regs);
			end
			send_cell(directed_rows[i].stim);
			if (directed_rows[i].typed) begin
				foreach (colors[k])
					colors[k] = directed_rows[i].color;
				queue_line(directed_rows[i].stim, directed_rows[i].scr, directed_rows[i].clr,
					directed_rows[i].pat, colors);
			end else begin
				predict_line(directed_rows[i].stim);
			end
			maybe_pause(1'b1);
		end

		// Random part: a fresh register setting per phase, no idling in the last one.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_pixels();
			foreach (regs[r])
				regs[r] = 7'($urandom_range(0, 127));
			if ($urandom_range(0, 3) == 0)
				regs[REG_COLUMNS] = 7'd0;
			program_regs(regs);
			for (int n = 0; n < LINES_PER_PHASE; n++) begin
				// Once mid-phase, wait for the block to empty completely.
				if (p == 3 && n == LINES_PER_PHASE / 2)
					drain_pixels();
				c = cell_t'($urandom);
				c.column = 7'($urandom);
				c.pattern = 8'($urandom);
				send_cell(c);
				predict_line(c);
				maybe_pause(p < RANDOM_PHASES - 1);
			end
		end

		drain_pixels();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d cell lines (%0d directed) under %0d register settings;",
			lines_sent, NUM_DIRECTED, settings_used + 1);
		$display("%0d pixels compared, %0d mismatching fields.", pixels_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
